### src/srarq_pkg.sv
// Shared types, codes and constants of the selective-repeat ARQ sender.
package srarq_pkg;

  localparam int MAX_FRAMES_DEF = 32;
  localparam int SEQ_COUNT_DEF  = 8;
  localparam int MAX_RESULTS    = 4;

  localparam logic [2:0] FN_LOAD  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_ACK   = 3'd2;
  localparam logic [2:0] FN_NAK   = 3'd3;
  localparam logic [2:0] FN_TICK  = 3'd4;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;
  localparam logic [CFG_AW-1:0] CFG_WINDOW      = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FAULT_MODE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FAULT_FRAME = 2'd2;

  localparam logic [1:0] FM_SKIP    = 2'd1;
  localparam logic [1:0] FM_CORRUPT = 2'd2;

  localparam logic [2:0] WIN_RESET    = 3'd3;
  localparam logic [2:0] WIN_MIN      = 3'd1;
  localparam logic [2:0] WIN_MAX      = 3'd4;
  localparam logic [7:0] CORRUPT_BYTE = 8'h58;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_PHASE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic [4:0] frame_index;
  } in_word_t;

  typedef struct packed {
    logic       frame_valid;
    logic [4:0] sent_index;
    logic [2:0] seq_num;
    logic [7:0] payload;
    logic [7:0] frame_sum;
    logic       is_resend;
    logic       last;
    logic       all_done;
    status_t    status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SLIDE,
    S_SCAN,
    S_FILL,
    S_LAND,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SRC_FIDX,
    SRC_NEXT,
    SRC_SCAN
  } idx_src_t;

  typedef struct packed {
    logic     latch_in;
    logic     do_load;
    logic     err_valid;
    status_t  err_code;
    logic     do_start;
    logic     set_ack;
    logic     slide_step;
    logic     slide_end;
    logic     scan_init;
    logic     scan_step;
    logic     ack_sel_scan;
    logic     issue;
    idx_src_t src;
    logic     resend;
    logic     fill_adv;
    logic     land;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       running;
    logic       loaded_zero;
    logic       fidx_bad;
    logic       can_fill;
    logic       fault_skip;
    logic       scan_ok;
    logic       scan_acked;
    logic       slide_more;
    logic       pend_valid;
    logic       out_free;
  } dp_stat_t;

endpackage

### src/srarq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srarq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### src/srarq_dp.sv
// Datapath of the ARQ sender: window state, frame store, emission path and result registers.
module srarq_dp import srarq_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int SEQ_COUNT  = SEQ_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int IW = $clog2(MAX_FRAMES);
  localparam int RECIP = (1 << IW) / SEQ_COUNT;
  localparam logic [IW-1:0] RECIP_L = IW'(RECIP);
  localparam logic [8:0]    SEQ_L   = 9'(SEQ_COUNT);
  localparam logic [IW:0]   SEQ_W   = (IW + 1)'(SEQ_COUNT);
  localparam logic [CW-1:0] MAX_L   = CW'(MAX_FRAMES);

  logic [2:0] win_r;
  logic [1:0] mode_r;
  logic [4:0] ff_r;

  in_word_t        in_r;
  logic [CW-1:0]   loaded_r, base_r, next_r, scan_r;
  logic            running_r, armed_r;
  logic [MAX_FRAMES-1:0] acked_r;
  logic [2:0]      n_r;
  status_t         status_r;

  logic [IW-1:0]   e_idx_r, q_r;
  logic            e_resend_r, e_corrupt_r;
  logic            pend_valid_r;
  out_word_t       pend_r;
  logic            out_valid_r;
  out_word_t       out_r;

  logic [2:0]      win_eff;
  logic [CW:0]     win_lim;
  logic            done;
  logic [CW-1:0]   load_base;
  logic            full_eff;
  logic            fault_hit, fault_skip, fault_corrupt;
  logic [IW-1:0]   issue_idx, ack_idx, fidx_i;
  logic [2*IW-1:0] prod_q;
  logic [IW+8:0]   prod_m;
  logic [IW:0]     r0, rmod;
  logic            ram_we;
  logic [IW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic            out_free;
  out_word_t       new_frame, status_word, push_word;
  logic            push;

  always_comb begin
    if (win_r == 3'd0) begin
      win_eff = WIN_MIN;
    end else if (win_r > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = win_r;
    end
  end

  assign win_lim   = {1'b0, base_r} + (CW + 1)'(win_eff);
  assign done      = (loaded_r != '0) && (base_r >= loaded_r);
  assign load_base = done ? '0 : loaded_r;
  assign full_eff  = (load_base == MAX_L);
  assign fidx_i    = IW'(in_r.frame_index);

  assign fault_hit     = armed_r && (32'(ff_r) == 32'(next_r));
  assign fault_skip    = fault_hit && (mode_r == FM_SKIP);
  assign fault_corrupt = fault_hit && (mode_r == FM_CORRUPT);

  always_comb begin
    case (cmd.src)
      SRC_FIDX: issue_idx = fidx_i;
      SRC_NEXT: issue_idx = IW'(next_r);
      SRC_SCAN: issue_idx = IW'(scan_r);
      default:  issue_idx = IW'(next_r);
    endcase
  end

  assign ack_idx = cmd.ack_sel_scan ? IW'(scan_r) : IW'(base_r);

  // Sequence number by reciprocal multiply; the quotient may be one short.
  assign prod_q = (2 * IW)'(issue_idx) * (2 * IW)'(RECIP_L);
  assign prod_m = (IW + 9)'(q_r) * (IW + 9)'(SEQ_L);
  assign r0     = {1'b0, e_idx_r} - prod_m[IW:0];
  assign rmod   = (int'(r0) >= SEQ_COUNT) ? (r0 - SEQ_W) : r0;

  assign ram_we    = cmd.do_load && !running_r && !full_eff;
  assign ram_raddr = cmd.issue ? issue_idx : e_idx_r;

  srarq_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(load_base)),
    .wdata (in_r.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    new_frame             = '0;
    new_frame.frame_valid = 1'b1;
    new_frame.sent_index  = 5'(e_idx_r);
    new_frame.seq_num     = rmod[2:0];
    new_frame.payload     = e_corrupt_r ? CORRUPT_BYTE : ram_rdata;
    new_frame.frame_sum   = ram_rdata;
    new_frame.is_resend   = e_resend_r;
    new_frame.status      = ST_OK;

    status_word          = '0;
    status_word.last     = 1'b1;
    status_word.all_done = done;
    status_word.status   = status_r;

    push      = 1'b0;
    push_word = pend_r;
    push_word.all_done = done;
    if (cmd.land && pend_valid_r) begin
      push = 1'b1;
    end else if (cmd.finish) begin
      push = 1'b1;
      if (pend_valid_r) begin
        push_word.last = 1'b1;
      end else begin
        push_word = status_word;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.func        = in_r.func;
    stat.running     = running_r;
    stat.loaded_zero = (loaded_r == '0);
    stat.fidx_bad    = 32'(in_r.frame_index) >= 32'(loaded_r);
    stat.can_fill    = running_r && (next_r < loaded_r) && ({1'b0, next_r} < win_lim) &&
                       (n_r < 3'(MAX_RESULTS));
    stat.fault_skip  = fault_skip;
    stat.scan_ok     = (scan_r < next_r) && (scan_r < loaded_r) && (n_r < 3'(MAX_RESULTS));
    stat.scan_acked  = acked_r[ack_idx];
    stat.slide_more  = (base_r < loaded_r) && acked_r[ack_idx];
    stat.pend_valid  = pend_valid_r;
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= WIN_RESET;
      mode_r       <= '0;
      ff_r         <= '0;
      loaded_r     <= '0;
      base_r       <= '0;
      next_r       <= '0;
      running_r    <= 1'b0;
      armed_r      <= 1'b1;
      acked_r      <= '0;
      n_r          <= '0;
      status_r     <= ST_OK;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WINDOW:      win_r  <= cfg_wdata[2:0];
          CFG_FAULT_MODE:  mode_r <= cfg_wdata[1:0];
          CFG_FAULT_FRAME: ff_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.latch_in) begin
        n_r      <= '0;
        status_r <= ST_OK;
      end
      if (cmd.err_valid) begin
        status_r <= cmd.err_code;
      end
      if (cmd.do_load && !running_r) begin
        if (done) begin
          base_r <= '0;
          next_r <= '0;
        end
        if (full_eff) begin
          status_r <= ST_FULL;
        end else begin
          loaded_r <= load_base + CW'(1);
        end
      end
      if (cmd.do_start) begin
        acked_r   <= '0;
        base_r    <= '0;
        next_r    <= '0;
        armed_r   <= 1'b1;
        running_r <= 1'b1;
      end
      if (cmd.set_ack) begin
        acked_r[fidx_i] <= 1'b1;
      end
      if (cmd.slide_step) begin
        base_r <= base_r + CW'(1);
      end
      if (cmd.slide_end && (base_r >= loaded_r)) begin
        running_r <= 1'b0;
        if (next_r < base_r) begin
          next_r <= base_r;
        end
      end
      if (cmd.fill_adv) begin
        next_r <= next_r + CW'(1);
        if (fault_skip || fault_corrupt) begin
          armed_r <= 1'b0;
        end
      end
      if (cmd.issue) begin
        n_r <= n_r + 3'd1;
      end
      if (cmd.land) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_word;
    end
    if (cmd.scan_init) begin
      scan_r <= base_r;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + CW'(1);
    end
    if (cmd.issue) begin
      e_idx_r     <= issue_idx;
      e_resend_r  <= cmd.resend;
      e_corrupt_r <= (cmd.src == SRC_NEXT) && fault_corrupt;
      q_r         <= prod_q[2*IW-1:IW];
    end
    if (cmd.land) begin
      pend_r <= new_frame;
    end
    if (push) begin
      out_r <= push_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### src/srarq_ctrl.sv
// Controller state machine of the ARQ sender: decodes each word and sequences the datapath.
module srarq_ctrl import srarq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   ret_scan_r, ret_scan_nxt;
  logic   land_ok;

  assign land_ok = !stat.pend_valid || stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_scan_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_scan_r <= ret_scan_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_scan_nxt = ret_scan_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.func)
          FN_START: begin
            if (!stat.running && !stat.loaded_zero) begin
              state_nxt = S_FILL;
            end
          end
          FN_ACK: begin
            if (stat.running && !stat.fidx_bad) begin
              state_nxt = S_SLIDE;
            end
          end
          FN_NAK: begin
            if (stat.running && !stat.fidx_bad) begin
              state_nxt    = S_LAND;
              ret_scan_nxt = 1'b0;
            end
          end
          FN_TICK: begin
            if (stat.running) begin
              state_nxt = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SLIDE: begin
        if (!stat.slide_more) begin
          state_nxt = S_FILL;
        end
      end
      S_SCAN: begin
        if (!stat.scan_ok) begin
          state_nxt = S_FILL;
        end else if (!stat.scan_acked) begin
          state_nxt    = S_LAND;
          ret_scan_nxt = 1'b1;
        end
      end
      S_FILL: begin
        if (!stat.can_fill) begin
          state_nxt = S_FINISH;
        end else if (!stat.fault_skip) begin
          state_nxt    = S_LAND;
          ret_scan_nxt = 1'b0;
        end
      end
      S_LAND: begin
        if (land_ok) begin
          state_nxt = ret_scan_r ? S_SCAN : S_FILL;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_NEXT;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        cmd.err_code = ST_PHASE;
        case (stat.func)
          FN_LOAD: begin
            if (stat.running) begin
              cmd.err_valid = 1'b1;
            end else begin
              cmd.do_load = 1'b1;
            end
          end
          FN_START: begin
            if (stat.running || stat.loaded_zero) begin
              cmd.err_valid = 1'b1;
            end else begin
              cmd.do_start = 1'b1;
            end
          end
          FN_ACK, FN_NAK: begin
            if (!stat.running) begin
              cmd.err_valid = 1'b1;
            end else if (stat.fidx_bad) begin
              cmd.err_valid = 1'b1;
              cmd.err_code  = ST_BAD_INDEX;
            end else if (stat.func == FN_ACK) begin
              cmd.set_ack = 1'b1;
            end else begin
              cmd.issue  = 1'b1;
              cmd.src    = SRC_FIDX;
              cmd.resend = 1'b1;
            end
          end
          FN_TICK: begin
            if (stat.running) begin
              cmd.scan_init = 1'b1;
            end else begin
              cmd.err_valid = 1'b1;
            end
          end
          default: cmd.err_valid = 1'b1;
        endcase
      end
      S_SLIDE: begin
        cmd.slide_step = stat.slide_more;
        cmd.slide_end  = !stat.slide_more;
      end
      S_SCAN: begin
        cmd.ack_sel_scan = 1'b1;
        cmd.src          = SRC_SCAN;
        cmd.resend       = 1'b1;
        cmd.scan_step    = stat.scan_ok;
        cmd.issue        = stat.scan_ok && !stat.scan_acked;
      end
      S_FILL: begin
        cmd.fill_adv = stat.can_fill;
        cmd.issue    = stat.can_fill && !stat.fault_skip;
      end
      S_LAND: begin
        cmd.land = land_ok;
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

### src/selective_repeat_arq_sender_core.sv
// Top level of the selective-repeat ARQ sender core.
//
//   channel  | handshake             | word
//   input    | in_valid / in_ready   | in_word  (func, data_byte, frame_index)
//   result   | out_valid / out_ready | out_word (one word per frame, or one status word)
//   config   | cfg_we                | cfg_addr, cfg_wdata
//
// A load or a rejected word passes from acceptance through the decode and finish states, and
// its result is placed in the finish state. A start, ack, nak or timeout also passes through
// the fill state, the land state for each frame sent (a nak's own frame from decode), a fill
// pass for each skipped fault frame, a slide or scan step for each base step or acknowledged
// entry passed by a scan, and a last slide or scan step that ends an ack's slide or a scan.
// Reset is synchronous and needs no clearing pass. A full result register stalls the
// controller wherever a further word must be placed behind it.
module selective_repeat_arq_sender_core import srarq_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int SEQ_COUNT  = SEQ_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srarq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srarq_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .SEQ_COUNT  (SEQ_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.pend_valid)
    else $error("input taken while a frame is still pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while the first is at work");

  a_frame_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_valid |-> out_word.status == ST_OK)
    else $error("sent frame carries an error status");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.frame_valid |-> out_word.last)
    else $error("status word not marked as last");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the selective-repeat ARQ sender core.
`timescale 1ns / 1ps

module testbench;
  import srarq_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int END_SETTLE     = 40;

  localparam logic [1:0] FM_NORMAL = 2'd0;
  localparam logic [1:0] FM_SPARE  = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_word   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // Predicted state of the sender.
  logic [7:0]  m_store [MAX_FRAMES_DEF];
  logic        m_acked [MAX_FRAMES_DEF];
  int unsigned m_loaded  = 0;
  int unsigned m_base    = 0;
  int unsigned m_next    = 0;
  logic        m_running = 1'b0;
  logic        m_armed   = 1'b1;
  logic [2:0]  m_win     = WIN_RESET;
  logic [1:0]  m_fmode   = FM_NORMAL;
  logic [4:0]  m_fframe  = '0;

  out_word_t   step_words [$];
  out_word_t   frames_due [$];
  out_word_t   want_word;

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  logic        rx_hold        = 1'b0;
  int          quiet_cycles   = 0;
  int          fail_count     = 0;
  int          words_sent     = 0;
  int          frames_checked = 0;
  int          resends_seen   = 0;

  selective_repeat_arq_sender_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (m_store[i]) begin
      m_store[i] = '0;
      m_acked[i] = 1'b0;
    end
  end

  function automatic in_word_t mk(logic [2:0] f, logic [7:0] d, logic [4:0] i);
    in_word_t w;
    w.func        = f;
    w.data_byte   = d;
    w.frame_index = i;
    return w;
  endfunction

  function automatic void emit_frame(int unsigned idx, logic [7:0] pay, logic resend);
    out_word_t f;
    if (step_words.size() < MAX_RESULTS) begin
      f             = '0;
      f.frame_valid = 1'b1;
      f.sent_index  = idx[4:0];
      f.seq_num     = 3'(idx % SEQ_COUNT_DEF);
      f.payload     = pay;
      f.frame_sum   = m_store[idx];
      f.is_resend   = resend;
      f.status      = ST_OK;
      step_words.push_back(f);
    end
  endfunction

  function automatic void fill_window();
    int unsigned win;
    int unsigned idx;
    win = (m_win < WIN_MIN) ? WIN_MIN : (m_win > WIN_MAX) ? WIN_MAX : m_win;
    while (m_running && m_next < m_loaded && m_next < m_base + win &&
           step_words.size() < MAX_RESULTS) begin
      idx = m_next;
      m_next++;
      if (m_armed && m_fframe == idx && m_fmode == FM_SKIP) begin
        m_armed = 1'b0;
      end else if (m_armed && m_fframe == idx && m_fmode == FM_CORRUPT) begin
        m_armed = 1'b0;
        emit_frame(idx, CORRUPT_BYTE, 1'b0);
      end else begin
        emit_frame(idx, m_store[idx], 1'b0);
      end
    end
  endfunction

  // Works out the result words of one accepted input word and queues them.
  function automatic void arq_predict(in_word_t w);
    status_t   st;
    out_word_t blank;
    logic      done;
    st = ST_OK;
    step_words.delete();
    case (w.func)
      FN_LOAD: begin
        if (m_running) begin
          st = ST_PHASE;
        end else begin
          if (m_loaded != 0 && m_base >= m_loaded) begin
            m_loaded = 0;
            m_base   = 0;
            m_next   = 0;
          end
          if (m_loaded >= MAX_FRAMES_DEF) begin
            st = ST_FULL;
          end else begin
            m_store[m_loaded] = w.data_byte;
            m_loaded++;
          end
        end
      end
      FN_START: begin
        if (m_running || m_loaded == 0) begin
          st = ST_PHASE;
        end else begin
          foreach (m_acked[i]) m_acked[i] = 1'b0;
          m_base    = 0;
          m_next    = 0;
          m_armed   = 1'b1;
          m_running = 1'b1;
          fill_window();
        end
      end
      FN_ACK, FN_NAK, FN_TICK: begin
        if (!m_running) begin
          st = ST_PHASE;
        end else if (w.func == FN_TICK) begin
          for (int unsigned i = m_base; i < m_next && i < m_loaded; i++)
            if (!m_acked[i]) emit_frame(i, m_store[i], 1'b1);
          fill_window();
        end else if (w.frame_index >= m_loaded) begin
          st = ST_BAD_INDEX;
        end else if (w.func == FN_ACK) begin
          m_acked[w.frame_index] = 1'b1;
          while (m_base < m_loaded && m_acked[m_base]) m_base++;
          if (m_base >= m_loaded) begin
            m_running = 1'b0;
            if (m_next < m_base) m_next = m_base;
          end
          fill_window();
        end else begin
          emit_frame(w.frame_index, m_store[w.frame_index], 1'b1);
          fill_window();
        end
      end
      default: st = ST_PHASE;
    endcase
    if (step_words.size() == 0) begin
      blank        = '0;
      blank.status = st;
      step_words.push_back(blank);
    end
    done = (m_loaded != 0 && m_base >= m_loaded);
    foreach (step_words[k]) begin
      step_words[k].all_done = done;
      step_words[k].last     = (k == step_words.size() - 1);
      frames_due.push_back(step_words[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (frames_due.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        fail_count++;
      end else begin
        want_word = frames_due.pop_front();
        check_field("frame_valid", want_word.frame_valid, out_word.frame_valid);
        check_field("sent_index", want_word.sent_index, out_word.sent_index);
        check_field("seq_num", want_word.seq_num, out_word.seq_num);
        check_field("payload", want_word.payload, out_word.payload);
        check_field("frame_sum", want_word.frame_sum, out_word.frame_sum);
        check_field("is_resend", want_word.is_resend, out_word.is_resend);
        check_field("last", want_word.last, out_word.last);
        check_field("all_done", want_word.all_done, out_word.all_done);
        check_field("status", want_word.status, out_word.status);
        if (want_word.frame_valid) frames_checked++;
        if (want_word.is_resend) resends_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    arq_predict(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    case (addr)
      CFG_WINDOW:      m_win    = value[2:0];
      CFG_FAULT_MODE:  m_fmode  = value[1:0];
      CFG_FAULT_FRAME: m_fframe = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drives link events until every frame of the running message is acknowledged.
  task automatic run_link(input int cap);
    int       steps;
    int       r;
    in_word_t w;
    steps = 0;
    while (m_running) begin
      r = $urandom_range(99);
      if (steps >= cap) begin
        w = mk(FN_ACK, 8'($urandom), 5'(m_base));
      end else if (r < 50 && m_next > m_base) begin
        w = mk(FN_ACK, 8'($urandom), 5'($urandom_range(m_next - 1, m_base)));
      end else if (r < 60) begin
        w = mk(FN_ACK, 8'($urandom), 5'($urandom_range(m_loaded - 1)));
      end else if (r < 70) begin
        w = mk(FN_NAK, 8'($urandom), 5'($urandom_range(m_loaded - 1)));
      end else if (r < 82) begin
        w = mk(FN_TICK, 8'($urandom), 5'($urandom));
      end else if (r < 90 && m_loaded < MAX_FRAMES_DEF) begin
        w = mk($urandom_range(1) ? FN_ACK : FN_NAK, 8'($urandom),
               5'($urandom_range(MAX_FRAMES_DEF - 1, m_loaded)));
      end else begin
        w = in_word_t'(16'($urandom));
      end
      send_word(w);
      steps++;
    end
  endtask

  task automatic run_message(input int len, input int extra_loads, input int cap);
    for (int k = 0; k < len + extra_loads; k++)
      send_word(mk(FN_LOAD, 8'($urandom), 5'($urandom)));
    send_word(mk(FN_START, 8'($urandom), 5'($urandom)));
    run_link(cap);
    if ($urandom_range(3) == 0) begin
      send_word(mk(FN_START, 8'($urandom), 5'($urandom)));
      run_link(cap);
    end
  endtask

  task automatic test_idle_rejects();
    send_word(mk(FN_ACK, 8'h00, 5'd31));
    send_word(mk(FN_NAK, 8'hFF, 5'd0));
    send_word(mk(FN_TICK, 8'h00, 5'd0));
    send_word(mk(FN_START, 8'h00, 5'd0));
    for (int f = FN_TICK + 1; f <= 7; f++)
      send_word(mk(3'(f), 8'h5A, 5'd17));
  endtask

  task automatic test_basic_message();
    send_word(mk(FN_LOAD, 8'h00, 5'd0));
    send_word(mk(FN_LOAD, 8'hFF, 5'd31));
    send_word(mk(FN_LOAD, 8'hA5, 5'd0));
    send_word(mk(FN_START, 8'h00, 5'd0));
    send_word(mk(FN_LOAD, 8'h11, 5'd0));
    send_word(mk(FN_START, 8'h00, 5'd0));
    send_word(mk(FN_ACK, 8'h00, 5'd31));
    send_word(mk(FN_NAK, 8'h00, 5'd3));
    send_word(mk(FN_NAK, 8'h00, 5'd1));
    send_word(mk(FN_ACK, 8'h00, 5'd1));
    send_word(mk(FN_TICK, 8'h00, 5'd0));
    send_word(mk(FN_ACK, 8'h00, 5'd0));
    send_word(mk(FN_ACK, 8'h00, 5'd2));
    send_word(mk(FN_START, 8'h00, 5'd0));
    send_word(mk(FN_ACK, 8'h00, 5'd2));
    send_word(mk(FN_ACK, 8'h00, 5'd1));
    send_word(mk(FN_ACK, 8'h00, 5'd0));
  endtask

  task automatic test_store_full();
    write_reg(CFG_WINDOW, 5'(WIN_MAX));
    write_reg(CFG_FAULT_MODE, 5'(FM_CORRUPT));
    write_reg(CFG_FAULT_FRAME, 5'd31);
    run_message(MAX_FRAMES_DEF, 2, 16);
  endtask

  task automatic test_window_sizes();
    int sizes [6];
    sizes = '{0, 5, 6, 7, 1, 2};
    write_reg(CFG_FAULT_MODE, 5'(FM_NORMAL));
    foreach (sizes[k]) begin
      write_reg(CFG_WINDOW, 5'(sizes[k]));
      run_message($urandom_range(5, 1), 0, 30);
    end
  endtask

  task automatic test_fault_injection();
    logic [1:0] modes [5];
    int         len;
    modes = '{FM_SKIP, FM_CORRUPT, FM_SPARE, FM_SKIP, FM_CORRUPT};
    foreach (modes[k]) begin
      len = $urandom_range(6, 3);
      write_reg(CFG_WINDOW, 5'($urandom_range(WIN_MAX, WIN_MIN)));
      write_reg(CFG_FAULT_MODE, 5'(modes[k]));
      write_reg(CFG_FAULT_FRAME, (k < 2) ? 5'd0 : 5'($urandom_range(len - 1)));
      run_message(len, 0, 30);
    end
    write_reg(CFG_FAULT_MODE, 5'(FM_NORMAL));
  endtask

  task automatic test_random_traffic();
    int unsigned idle_pcts  [4];
    int unsigned stall_pcts [4];
    int          goal;
    int          r;
    int          len;
    idle_pcts  = '{0, 70, 0, 19};
    stall_pcts = '{0, 0, 70, 19};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pcts[p];
      stall_pct     = stall_pcts[p];
      goal          = words_sent + 12;
      while (words_sent < goal) begin
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1)) write_reg(CFG_WINDOW, 5'($urandom_range(7)));
          if ($urandom_range(1)) write_reg(CFG_FAULT_MODE, 5'($urandom_range(3)));
          if ($urandom_range(1)) write_reg(CFG_FAULT_FRAME, 5'($urandom_range(15)));
        end
        if ($urandom_range(6) == 0) begin
          repeat ($urandom_range(3, 1))
            send_word(mk(3'($urandom_range(7, FN_ACK)), 8'($urandom), 5'($urandom)));
        end
        r = $urandom_range(99);
        if (r < 80) len = $urandom_range(8, 1);
        else if (r < 95) len = $urandom_range(20, 9);
        else len = MAX_FRAMES_DEF;
        run_message(len, (len == MAX_FRAMES_DEF) ? 1 : 0, 40);
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WINDOW, 5'(WIN_MAX));
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    run_message(16, 0, 20);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_rejects();
    test_basic_message();
    test_store_full();
    test_window_sizes();
    test_fault_injection();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (END_SETTLE) @(negedge clk);
    $display("Covered %0d input words and %0d frames, %0d of them resends,",
             words_sent, frames_checked, resends_seen);
    $display("over window sizes 0 to 7, all fault modes, four pacing phases and a long hold.");
    if (fail_count == 0 && frames_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
